>>> src/rcw_pkg.sv
package rcw_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned SEQ_W = 32;
  localparam int unsigned OP_W = 3;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [CNT_W-1:0] INIT_WINDOW_RST = 16'd10;
  localparam logic [CNT_W-1:0] INIT_THRESHOLD_RST = 16'hFFFF;
  localparam logic [CNT_W-1:0] WINDOW_FLOOR = 16'd1;
  localparam logic [CNT_W-1:0] THRESHOLD_FLOOR = 16'd2;

  localparam logic REG_INIT_WINDOW = 1'b0;
  localparam logic REG_INIT_THRESHOLD = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_START        = 3'd0,
    OP_FIRST_ACK    = 3'd1,
    OP_DUPACK       = 3'd2,
    OP_RECOVERY_ACK = 3'd3,
    OP_PARTIAL_ACK  = 3'd4,
    OP_TIMEOUT      = 3'd5
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SLOW_START = 2'd0,
    MODE_AVOIDANCE  = 2'd1,
    MODE_RECOVERY   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] start_window;
    logic [CNT_W-1:0] start_threshold;
  } cfg_t;

  // segment count with floor, to fixed point, saturated to 32 bits
  function automatic logic [VAL_W-1:0] load_fixed(logic [CNT_W-1:0] v,
                                                  logic [CNT_W-1:0] floor_v,
                                                  int unsigned frac);
    logic [CNT_W-1:0] m;
    logic [47:0] w;
    m = (v < floor_v) ? floor_v : v;
    w = {32'd0, m} << frac;
    return (|w[47:32]) ? {VAL_W{1'b1}} : w[VAL_W-1:0];
  endfunction

endpackage

>>> src/rcw_cfg.sv
module rcw_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rcw_pkg::APB_AW-1:0] paddr,
  input  logic [rcw_pkg::APB_DW-1:0] pwdata,
  output logic [rcw_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output rcw_pkg::cfg_t             cfg
);
  import rcw_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_window <= INIT_WINDOW_RST;
      cfg.start_threshold <= INIT_THRESHOLD_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_INIT_THRESHOLD) begin
        cfg.start_threshold <= pwdata[CNT_W-1:0];
      end else begin
        cfg.start_window <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_INIT_THRESHOLD) begin
      prdata = APB_DW'(cfg.start_threshold);
    end else begin
      prdata = APB_DW'(cfg.start_window);
    end
  end

endmodule

>>> src/rcw_div.sv
module rcw_div #(
  parameter int unsigned FRAC_BITS = rcw_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rcw_pkg::CNT_W-1:0] count,
  input  logic [rcw_pkg::VAL_W-1:0] divisor,
  output logic                      busy,
  output logic [rcw_pkg::VAL_W-1:0] quotient
);
  import rcw_pkg::*;

  // dividend is count followed by 2*FRAC_BITS zero bits, one bit per cycle
  localparam int unsigned DW = CNT_W + 2 * FRAC_BITS;
  localparam int unsigned STEP_W = $clog2(DW + 1);

  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  cnt_sr;
  logic [VAL_W-1:0]  dvs;
  logic [VAL_W-1:0]  rem;
  logic [VAL_W-1:0]  q;
  logic              ovf;
  logic [VAL_W:0]    trial;
  logic              ge;

  assign busy = (steps != '0);
  assign trial = {rem, cnt_sr[CNT_W-1]};
  assign ge = (trial >= {1'b0, dvs});
  assign quotient = ovf ? {VAL_W{1'b1}} : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(DW);
    end else if (busy) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_sr <= count;
      dvs <= (divisor == '0) ? VAL_W'(1) : divisor;
      rem <= '0;
      q <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      cnt_sr <= {cnt_sr[CNT_W-2:0], 1'b0};
      rem <= ge ? VAL_W'(trial - {1'b0, dvs}) : trial[VAL_W-1:0];
      q <= {q[VAL_W-2:0], ge};
      ovf <= ovf | q[VAL_W-1];
    end
  end

endmodule

>>> src/reno_congestion_window.sv
// most events: the item is registered, then the result is registered once the output is free
// a first ack in congestion avoidance also waits for the divide, which is done
// by the bit-serial divider producing one quotient bit per cycle
// a new item is accepted only after the previous result is committed;
// the next item is taken while a result waits at the output
// rst (synchronous) loads window 10.0, threshold 65535.0, slow start, recovery mark 0
module reno_congestion_window #(
  parameter int unsigned FRAC_BITS = rcw_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [47:0]                s_tdata,  // event_count, lost_sequence
  input  logic [rcw_pkg::OP_W-1:0]   s_tuser,  // operation
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // window_size, window_fixed, threshold_fixed, recovery_mark
  output logic [111:0]               m_tdata,
  output logic [rcw_pkg::MODE_W-1:0] m_tuser,  // cc_mode
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcw_pkg::APB_AW-1:0] paddr,
  input  logic [rcw_pkg::APB_DW-1:0] pwdata,
  output logic [rcw_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import rcw_pkg::*;

  localparam int unsigned CW = CNT_W + FRAC_BITS;
  localparam int unsigned SW = ((CW > VAL_W) ? CW : VAL_W) + 1;
  localparam logic [VAL_W-1:0] ONE_Q = VAL_W'(1) << FRAC_BITS;
  localparam logic [VAL_W-1:0] TWO_Q = VAL_W'(2) << FRAC_BITS;
  localparam logic [VAL_W-1:0] THREE_Q = VAL_W'(3) << FRAC_BITS;
  localparam logic [VAL_W-1:0] WINDOW_RST =
    load_fixed(INIT_WINDOW_RST, WINDOW_FLOOR, FRAC_BITS);
  localparam logic [VAL_W-1:0] THRESHOLD_RST =
    load_fixed(INIT_THRESHOLD_RST, THRESHOLD_FLOOR, FRAC_BITS);

  function automatic logic [VAL_W-1:0] sat_w(logic [SW-1:0] v);
    return (|v[SW-1:VAL_W]) ? {VAL_W{1'b1}} : v[VAL_W-1:0];
  endfunction

  cfg_t cfg;

  state_t state, state_next;
  logic [VAL_W-1:0] window_reg, window_next;
  logic [VAL_W-1:0] threshold_reg, threshold_next;
  mode_t            mode_reg, mode_next;
  logic [VAL_W-1:0] recovery_reg, recovery_next;

  op_t              op_reg;
  logic [CNT_W-1:0] cnt_reg;
  logic [SEQ_W-1:0] lost_reg;

  logic             div_start;
  logic             div_busy;
  logic [VAL_W-1:0] div_quo;
  logic             commit;
  logic             out_free;

  logic [SW-1:0]    cnt_fix;
  logic [VAL_W-1:0] halved;
  logic [VAL_W-1:0] half;
  logic [VAL_W-1:0] ip_wide;
  logic [CNT_W-1:0] size_next;

  rcw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcw_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .count    (s_tdata[CNT_W-1:0]),
    .divisor  (window_reg),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    div_start = 1'b0;
    commit = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (op_t'(s_tuser) == OP_FIRST_ACK && mode_reg == MODE_AVOIDANCE) begin
            div_start = 1'b1;
            state_next = ST_DIV;
          end else begin
            state_next = ST_COMMIT;
          end
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_reg <= op_t'(s_tuser);
      cnt_reg <= s_tdata[CNT_W-1:0];
      lost_reg <= s_tdata[CNT_W+SEQ_W-1:CNT_W];
    end
  end

  // next state of the congestion registers
  always_comb begin
    window_next = window_reg;
    threshold_next = threshold_reg;
    mode_next = mode_reg;
    recovery_next = recovery_reg;
    cnt_fix = SW'(cnt_reg) << FRAC_BITS;
    half = {1'b0, window_reg[VAL_W-1:1]};
    halved = (half < TWO_Q) ? TWO_Q : half;
    case (op_reg)
      OP_START: begin
        window_next = load_fixed(cfg.start_window, WINDOW_FLOOR, FRAC_BITS);
        threshold_next = load_fixed(cfg.start_threshold, THRESHOLD_FLOOR, FRAC_BITS);
        mode_next = MODE_SLOW_START;
        recovery_next = '0;
      end
      OP_FIRST_ACK: begin
        if (mode_reg == MODE_AVOIDANCE) begin
          window_next = sat_w(SW'(window_reg) + SW'(div_quo));
        end else begin
          window_next = sat_w(SW'(window_reg) + cnt_fix);
          if (mode_reg == MODE_SLOW_START && window_next >= threshold_reg) begin
            mode_next = MODE_AVOIDANCE;
          end
        end
      end
      OP_DUPACK: begin
        if (mode_reg != MODE_RECOVERY) begin
          threshold_next = halved;
          window_next = sat_w(SW'(halved) + SW'(THREE_Q));
          mode_next = MODE_RECOVERY;
        end
        if (lost_reg > recovery_reg) begin
          recovery_next = lost_reg;
        end
      end
      OP_RECOVERY_ACK: begin
        window_next = threshold_reg;
        mode_next = MODE_AVOIDANCE;
      end
      OP_PARTIAL_ACK: begin
        if (SW'(window_reg) < cnt_fix) begin
          window_next = ONE_Q;
        end else begin
          window_next = sat_w(SW'(window_reg) - cnt_fix + SW'(ONE_Q));
        end
      end
      OP_TIMEOUT: begin
        threshold_next = halved;
        window_next = ONE_Q;
        mode_next = MODE_SLOW_START;
      end
      default: begin
      end
    endcase
    ip_wide = window_next >> FRAC_BITS;
    if (ip_wide == '0) begin
      size_next = 16'd1;
    end else if (|ip_wide[VAL_W-1:CNT_W]) begin
      size_next = 16'hFFFF;
    end else begin
      size_next = ip_wide[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_reg <= WINDOW_RST;
      threshold_reg <= THRESHOLD_RST;
      mode_reg <= MODE_SLOW_START;
      recovery_reg <= '0;
    end else if (commit) begin
      window_reg <= window_next;
      threshold_reg <= threshold_next;
      mode_reg <= mode_next;
      recovery_reg <= recovery_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {recovery_next, threshold_next, window_next, size_next};
      m_tuser <= mode_next;
    end
  end

endmodule
